// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define GBW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that cons follows from ante at the same clock edge outside reset.
`define GBW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ----- design/gbw_pkg.sv -----
// Types, constants and codes of the grind-by-weight controller.
package gbw_pkg;

  typedef enum logic [1:0] {
    MODE_EMPTY    = 2'd0,
    MODE_GRINDING = 2'd1,
    MODE_FINISHED = 2'd2,
    MODE_FAILED   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REASON_NO_SAMPLE   = 2'd0,
    REASON_TIMEOUT     = 2'd1,
    REASON_CUP_REMOVED = 2'd2,
    REASON_NO_INCREASE = 2'd3
  } reason_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CUP_WEIGHT    = 3'd0,
    REG_CUP_TOLERANCE = 3'd1,
    REG_TARGET_WEIGHT = 3'd2,
    REG_MAX_GRIND_MS  = 3'd3,
    REG_TARE_INTERVAL = 3'd4
  } cfg_idx_e;

  // Weight thresholds in centigrams, time in milliseconds.
  localparam int RemoveLimitCg   = 500;
  localparam int ProgressDelayMs = 2000;
  localparam int MinGainCg       = 100;
  localparam int TareLowCg       = 20;
  localparam int TareHighCg      = 300;

  localparam logic [16:0] CupWeightRst    = 17'd30000;
  localparam logic [13:0] CupToleranceRst = 14'd1000;
  localparam logic [13:0] TargetWeightRst = 14'd1800;
  localparam logic [19:0] MaxGrindMsRst   = 20'd30000;
  localparam logic [19:0] TareIntervalRst = 20'd5000;

  typedef struct packed {
    logic               sample_ok;
    logic signed [23:0] weight;
    logic        [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic               grinder_on;
    logic               tare_request;
    logic               done_event;
    logic               fail_event;
    logic        [1:0]  fail_reason;
    logic signed [23:0] dose_weight;
    logic        [31:0] grind_ms;
  } out_t;

  typedef struct packed {
    logic [16:0] cup_weight;
    logic [13:0] cup_tolerance;
    logic [13:0] target_weight;
    logic [19:0] max_grind_ms;
    logic [19:0] tare_interval_ms;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic signed [23:0] empty_cup_weight;
    logic        [31:0] start_time;
    logic        [31:0] last_tare_time;
    logic               drive;
  } ctl_t;

endpackage

// ----- design/grind_by_weight_controller_core.sv -----
// Top level of the grind-by-weight controller.
// Grind-by-weight controller core. Each input transaction carries one filtered
// load-cell sample (signed centigrams), a sample-ok flag and a millisecond
// timestamp; each produces exactly one result transaction with the status after
// the step, the grinder drive level and the tare/done/fail events. Throughput is
// one transaction per clock cycle while out_ready_i does not stall the result
// register. The sample lands in the input register at the accepting edge, and
// the combinational decision logic feeds the result register when the input
// stage advances. The result register decouples the two channels, so a new
// sample is taken while a finished result still waits.
// The five configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i with no wait state; write them only while no transaction is in
// flight. Unknown register indexes are ignored. After reset the controller is
// in the empty state with the grinder off and all timestamps at zero.
module grind_by_weight_controller_core import gbw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg;
  ctl_t ctl_q, ctl_d;
  out_t res;
  in_t  s1_data_q;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  out_t out_data_q;
  logic advance;

  gbw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gbw_step u_step (
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .ctl_i  (ctl_q),
    .ctl_o  (ctl_d),
    .res_o  (res)
  );

  // Advance the input stage into the result register whenever that register
  // is empty or being emptied this cycle; controller state commits at the
  // same edge, so samples are applied strictly in arrival order.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_q.mode             <= MODE_EMPTY;
      ctl_q.empty_cup_weight <= '0;
      ctl_q.start_time       <= '0;
      ctl_q.last_tare_time   <= '0;
      ctl_q.drive            <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        ctl_q <= ctl_d;
      end
    end
  end

  // Payload registers: hold the sample and the result, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/gbw_cfg_regs.sv -----
// Configuration register file with a plain write port.
module gbw_cfg_regs import gbw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CUP_WEIGHT:    cfg_d.cup_weight       = cfg_wdata_i[16:0];
        REG_CUP_TOLERANCE: cfg_d.cup_tolerance    = cfg_wdata_i[13:0];
        REG_TARGET_WEIGHT: cfg_d.target_weight    = cfg_wdata_i[13:0];
        REG_MAX_GRIND_MS:  cfg_d.max_grind_ms     = cfg_wdata_i;
        REG_TARE_INTERVAL: cfg_d.tare_interval_ms = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cup_weight       <= CupWeightRst;
      cfg_q.cup_tolerance    <= CupToleranceRst;
      cfg_q.target_weight    <= TargetWeightRst;
      cfg_q.max_grind_ms     <= MaxGrindMsRst;
      cfg_q.tare_interval_ms <= TareIntervalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/gbw_step.sv -----
// Decision logic for one weight sample: next controller state and result.
module gbw_step import gbw_pkg::*; (
  input  in_t  item_i,
  input  cfg_t cfg_i,
  input  ctl_t ctl_i,
  output ctl_t ctl_o,
  output out_t res_o
);

  logic signed [25:0] w26, empty26, cup_diff, cup_abs, gain, low_lim;
  logic        [24:0] w_abs;
  logic        [31:0] elapsed, since_tare;
  logic               cup_ok, tare_ok, gain_big, gain_small;

  always_comb begin
    w26      = {{2{item_i.weight[23]}}, item_i.weight};
    empty26  = {{2{ctl_i.empty_cup_weight[23]}}, ctl_i.empty_cup_weight};
    cup_diff = w26 - $signed({9'b0, cfg_i.cup_weight});
    cup_abs  = cup_diff[25] ? -cup_diff : cup_diff;
    w_abs    = item_i.weight[23] ? -{item_i.weight[23], item_i.weight}
                                 : {item_i.weight[23], item_i.weight};
    gain     = w26 - empty26;
    low_lim  = empty26 - $signed({12'b0, cfg_i.cup_tolerance});
    elapsed    = item_i.now_ms - ctl_i.start_time;
    since_tare = item_i.now_ms - ctl_i.last_tare_time;

    cup_ok     = cup_abs < $signed({12'b0, cfg_i.cup_tolerance});
    tare_ok    = (since_tare >= {12'b0, cfg_i.tare_interval_ms})
              && (w_abs > 25'(TareLowCg)) && (w_abs < 25'(TareHighCg));
    gain_big   = gain > $signed(26'(8388607));
    gain_small = gain < $signed(-26'(8388608));

    ctl_o = ctl_i;
    res_o = '0;

    if (!item_i.sample_ok) begin
      ctl_o.drive       = 1'b0;
      ctl_o.mode        = MODE_FAILED;
      res_o.fail_event  = 1'b1;
      res_o.fail_reason = REASON_NO_SAMPLE;
    end else begin
      unique case (ctl_i.mode)
        MODE_EMPTY: begin
          if (cup_ok) begin
            ctl_o.empty_cup_weight = item_i.weight;
            ctl_o.mode             = MODE_GRINDING;
            ctl_o.start_time       = item_i.now_ms;
            ctl_o.drive            = 1'b1;
          end else if (tare_ok) begin
            res_o.tare_request     = 1'b1;
            ctl_o.last_tare_time   = item_i.now_ms;
            ctl_o.empty_cup_weight = '0;
          end
        end
        MODE_GRINDING: begin
          if (elapsed > {12'b0, cfg_i.max_grind_ms}) begin
            res_o.fail_event  = 1'b1;
            res_o.fail_reason = REASON_TIMEOUT;
          end else if (w26 < low_lim) begin
            res_o.fail_event  = 1'b1;
            res_o.fail_reason = REASON_CUP_REMOVED;
          end else if (elapsed > 32'(ProgressDelayMs) && gain < 26'(MinGainCg)) begin
            res_o.fail_event  = 1'b1;
            res_o.fail_reason = REASON_NO_INCREASE;
          end else if (gain >= $signed({12'b0, cfg_i.target_weight})) begin
            ctl_o.drive      = 1'b0;
            ctl_o.mode       = MODE_FINISHED;
            res_o.done_event = 1'b1;
            res_o.grind_ms   = elapsed;
            if (gain_big) begin
              res_o.dose_weight = 24'sh7FFFFF;
            end else if (gain_small) begin
              res_o.dose_weight = 24'sh800000;
            end else begin
              res_o.dose_weight = gain[23:0];
            end
          end
          if (res_o.fail_event) begin
            ctl_o.drive = 1'b0;
            ctl_o.mode  = MODE_FAILED;
          end
        end
        default: begin
          // finished or failed: drop back to empty once the cup is off
          if (w26 < 26'(RemoveLimitCg)) begin
            ctl_o.mode = MODE_EMPTY;
          end
        end
      endcase
    end

    res_o.status     = ctl_o.mode;
    res_o.grinder_on = ctl_o.drive;
  end

endmodule

// ----- design/gbw_checker.sv -----
// Port-level checker for the grind-by-weight controller, bound to the top level.
`include "assert_macros.svh"

module gbw_checker import gbw_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  logic stalled;
  logic done_ok, fail_ok, drive_ok, idle_fields;

  assign stalled  = out_valid_o && !out_ready_i;
  assign done_ok  = out_data_o.status == MODE_FINISHED && !out_data_o.grinder_on;
  assign fail_ok  = out_data_o.status == MODE_FAILED && !out_data_o.grinder_on;
  assign drive_ok = out_data_o.grinder_on == (out_data_o.status == MODE_GRINDING);
  assign idle_fields = (out_data_o.fail_event || out_data_o.fail_reason == REASON_NO_SAMPLE)
                    && (out_data_o.done_event
                        || (out_data_o.dose_weight == '0 && out_data_o.grind_ms == '0));

  `GBW_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, stalled, ##1 (out_valid_o && $stable(out_data_o)))
  `GBW_ASSERT_IMPL(a_done_stops, clk_i, rst_ni, out_valid_o && out_data_o.done_event, done_ok)
  `GBW_ASSERT_IMPL(a_fail_stops, clk_i, rst_ni, out_valid_o && out_data_o.fail_event, fail_ok)
  `GBW_ASSERT_IMPL(a_drive_mode, clk_i, rst_ni, out_valid_o, drive_ok)
  `GBW_ASSERT_IMPL(a_idle_fields, clk_i, rst_ni, out_valid_o, idle_fields)

endmodule

bind grind_by_weight_controller_core gbw_checker u_gbw_checker (.*);
